### src/spnbc_pkg.sv
// Shared types, constants and round functions of the 64-bit SPN block cipher.
package spnbc_pkg;

  localparam int BLOCK_W  = 64;
  localparam int KEY_ROT  = 13;
  localparam int RC_ROUND = 15;
  localparam int RC_BYTE  = 19;

  // Configuration register indexes.
  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW  = 1'b1;

  // Direction codes carried with each block.
  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  typedef struct packed {
    logic                 cmd;
    logic [BLOCK_W-1:0]   block;
  } item_t;

  function automatic logic [3:0] sbox_fwd(input logic [3:0] x);
    logic [3:0] y;
    unique case (x)
      4'h0: y = 4'h6;
      4'h1: y = 4'h4;
      4'h2: y = 4'hC;
      4'h3: y = 4'h5;
      4'h4: y = 4'h0;
      4'h5: y = 4'h7;
      4'h6: y = 4'h2;
      4'h7: y = 4'hE;
      4'h8: y = 4'h1;
      4'h9: y = 4'hF;
      4'hA: y = 4'h3;
      4'hB: y = 4'hD;
      4'hC: y = 4'h8;
      4'hD: y = 4'hA;
      4'hE: y = 4'h9;
      default: y = 4'hB;
    endcase
    return y;
  endfunction

  function automatic logic [3:0] nib_unsub(input logic [3:0] x);
    logic [3:0] y;
    unique case (x)
      4'h0: y = 4'd4;
      4'h1: y = 4'd8;
      4'h2: y = 4'd6;
      4'h3: y = 4'd10;
      4'h4: y = 4'd1;
      4'h5: y = 4'd3;
      4'h6: y = 4'd0;
      4'h7: y = 4'd5;
      4'h8: y = 4'd12;
      4'h9: y = 4'd14;
      4'hA: y = 4'd13;
      4'hB: y = 4'd15;
      4'hC: y = 4'd2;
      4'hD: y = 4'd11;
      4'hE: y = 4'd7;
      default: y = 4'd9;
    endcase
    return y;
  endfunction

  function automatic logic [BLOCK_W-1:0] sub_fwd(input logic [BLOCK_W-1:0] x);
    logic [BLOCK_W-1:0] y;
    for (int n = 0; n < BLOCK_W / 4; n++) begin
      y[4*n +: 4] = sbox_fwd(x[4*n +: 4]);
    end
    return y;
  endfunction

  function automatic logic [BLOCK_W-1:0] sub_inv(input logic [BLOCK_W-1:0] x);
    logic [BLOCK_W-1:0] y;
    for (int n = 0; n < BLOCK_W / 4; n++) begin
      y[4*n +: 4] = nib_unsub(x[4*n +: 4]);
    end
    return y;
  endfunction

  // Bit positions are counted from the most significant bit. The bit at
  // (byte j, bit c) moves to position 8c + ((j + c) mod 8).
  function automatic logic [BLOCK_W-1:0] perm_fwd(input logic [BLOCK_W-1:0] x);
    logic [BLOCK_W-1:0] y;
    for (int j = 0; j < 8; j++) begin
      for (int c = 0; c < 8; c++) begin
        y[63 - (8*c + ((j + c) & 7))] = x[63 - (8*j + c)];
      end
    end
    return y;
  endfunction

  function automatic logic [BLOCK_W-1:0] perm_inv(input logic [BLOCK_W-1:0] x);
    logic [BLOCK_W-1:0] y;
    for (int j = 0; j < 8; j++) begin
      for (int c = 0; c < 8; c++) begin
        y[63 - (8*j + c)] = x[63 - (8*c + ((j + c) & 7))];
      end
    end
    return y;
  endfunction

  // Round key r: top half of the 128-bit key rotated left by 13r bits, each
  // byte mixed with a round and byte dependent constant. With r fixed at
  // elaboration this reduces to wiring and XOR gates.
  function automatic logic [BLOCK_W-1:0] subkey_of(input logic [BLOCK_W-1:0] key_high,
                                                   input logic [BLOCK_W-1:0] key_low,
                                                   input int r);
    logic [2*BLOCK_W-1:0] full;
    logic [2*BLOCK_W-1:0] rot;
    logic [BLOCK_W-1:0]   w;
    int                   m;
    full = {key_high, key_low};
    m    = (KEY_ROT * r) & 127;
    rot  = (full << m) | (full >> (128 - m));
    w    = rot[2*BLOCK_W-1 -: BLOCK_W];
    for (int i = 0; i < 8; i++) begin
      w[63 - 8*i -: 8] = w[63 - 8*i -: 8] ^ 8'((r * RC_ROUND + i * RC_BYTE) & 255);
    end
    return w;
  endfunction

endpackage

### src/spnbc_cell.sv
// One round cell of the cipher pipeline: a registered round in either direction.
module spnbc_cell #(
  parameter int STAGE      = 0,
  parameter int NUM_ROUNDS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [spnbc_pkg::BLOCK_W-1:0]     key_high_i,
  input  logic [spnbc_pkg::BLOCK_W-1:0]     key_low_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  spnbc_pkg::item_t                  in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output spnbc_pkg::item_t                  out_item_o
);

  localparam int ENC_ROUND = STAGE;
  localparam int DEC_ROUND = NUM_ROUNDS - 1 - STAGE;

  logic [spnbc_pkg::BLOCK_W-1:0] rk_enc, rk_dec;
  logic [spnbc_pkg::BLOCK_W-1:0] enc_mix, enc_res, dec_pre, dec_res;
  logic                          valid_q;
  spnbc_pkg::item_t              item_d, item_q;
  logic                          load;

  assign rk_enc = spnbc_pkg::subkey_of(key_high_i, key_low_i, ENC_ROUND);
  assign rk_dec = spnbc_pkg::subkey_of(key_high_i, key_low_i, DEC_ROUND);

  // The last encryption round has no permutation; the first decryption
  // round has no inverse permutation.
  assign enc_mix = spnbc_pkg::sub_fwd(in_item_i.block) ^ rk_enc;
  assign enc_res = (STAGE < NUM_ROUNDS - 1) ? spnbc_pkg::perm_fwd(enc_mix) : enc_mix;
  assign dec_pre = (STAGE > 0) ? spnbc_pkg::perm_inv(in_item_i.block) : in_item_i.block;
  assign dec_res = spnbc_pkg::sub_inv(dec_pre ^ rk_dec);

  always_comb begin
    item_d.cmd   = in_item_i.cmd;
    item_d.block = (in_item_i.cmd == spnbc_pkg::CMD_DECRYPT) ? dec_res : enc_res;
  end

  assign in_ready_o = ~valid_q | out_ready_i;
  assign load       = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

### src/spn64_block_cipher.sv
// Top level of the 64-bit SPN block cipher: key registers and a chain of round cells.
//
// Usage: blocks enter on the slave stream channel (tdata holds the 64-bit
// block, byte 0 in the top byte; tuser holds the direction, 0 encrypt and
// 1 decrypt). Each block leaves on the master stream channel in the order it
// entered, one result transaction per input transaction.
// The 128-bit key sits in two 64-bit registers written through the
// configuration channel (index 0 key_high, index 1 key_low); the channel is
// always ready, and keys should be written only while no block is in flight.
// The core is a chain of NUM_ROUNDS round cells, one registered round per cell,
// and a new block may enter in every cycle while the receiver keeps tready high.
// Each cell computes its round keys for both directions from the key registers
// with fixed rotations, so the round logic between two registers is one S-box
// layer, one XOR and wiring.
// When the receiver deasserts tready, the stall propagates back through the
// chain: a cell holding a block takes a new one only when its own result
// moves on, so bubbles are squeezed out and nothing is dropped.
// Reset clears all cell valid flags and both key registers to zero.
module spn64_block_cipher #(
  parameter int NUM_ROUNDS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i,
  // Input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [63:0] block_in
  input  logic [0:0]  s_axis_tuser_i,   // [0] cmd
  // Output stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o    // [63:0] block_out
);

  logic [63:0]      key_high_q, key_high_d;
  logic [63:0]      key_low_q, key_low_d;

  // Handshake and payload between neighboring cells; index 0 is the input
  // side, index NUM_ROUNDS the output side.
  logic             valid_w [NUM_ROUNDS+1];
  logic             ready_w [NUM_ROUNDS+1];
  spnbc_pkg::item_t item_w  [NUM_ROUNDS+1];

  assign cfg_ready_o = 1'b1;

  always_comb begin
    key_high_d = key_high_q;
    key_low_d  = key_low_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        spnbc_pkg::REG_KEY_HIGH: key_high_d = cfg_data_i;
        spnbc_pkg::REG_KEY_LOW:  key_low_d  = cfg_data_i;
        default:                 key_high_d = key_high_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else begin
      key_high_q <= key_high_d;
      key_low_q  <= key_low_d;
    end
  end

  assign valid_w[0]       = s_axis_tvalid_i;
  assign s_axis_tready_o  = ready_w[0];
  assign item_w[0].cmd    = s_axis_tuser_i[0];
  assign item_w[0].block  = s_axis_tdata_i;

  for (genvar k = 0; k < NUM_ROUNDS; k++) begin : g_cell
    spnbc_cell #(
      .STAGE      (k),
      .NUM_ROUNDS (NUM_ROUNDS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .key_high_i  (key_high_q),
      .key_low_i   (key_low_q),
      .in_valid_i  (valid_w[k]),
      .in_ready_o  (ready_w[k]),
      .in_item_i   (item_w[k]),
      .out_valid_o (valid_w[k+1]),
      .out_ready_i (ready_w[k+1]),
      .out_item_o  (item_w[k+1])
    );
  end

  assign ready_w[NUM_ROUNDS] = m_axis_tready_i;
  assign m_axis_tvalid_o     = valid_w[NUM_ROUNDS];
  assign m_axis_tdata_o      = item_w[NUM_ROUNDS].block;

endmodule
